[sv/mf2d_pkg.sv]
// shared constants, types and register codes for the 2-d median filter
// no dependencies; used by the interfaces, the median unit and the top level
`default_nettype none

package mf2d_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_WINDOW = 7;
	localparam int RMAX       = (MAX_WINDOW - 1) / 2;
	localparam int WIN_N      = MAX_WINDOW * MAX_WINDOW;
	localparam int MED_IDX    = WIN_N / 2;
	localparam int RANK_W     = $clog2(WIN_N);

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 11;
	localparam int RAD_W  = 2;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
	localparam int PEND_W = 13;

	// line memory: one word per column, one byte lane per row modulo BANKS
	localparam int BANKS  = 8;
	localparam int BANK_W = $clog2(BANKS);
	localparam int WORD_W = BANKS * PIX_W;

	typedef enum logic [RAD_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [MAX_WINDOW-1:0] column_t;
	typedef pix_t [WIN_N-1:0] window_t;

	typedef struct packed {
		logic valid;
		logic last;
	} med_ctl_t;

endpackage

`default_nettype wire

[sv/mf2d_if.sv]
// request channels of the median filter: pixel/flush input and result output
// depends on mf2d_pkg for the pixel width
`default_nettype none

interface mf2d_in_if;
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic [mf2d_pkg::PIX_W-1:0] pixel;
	modport source (output valid, command, pixel, input ready);
	modport sink (input valid, command, pixel, output ready);
endinterface

interface mf2d_out_if;
	logic                    valid;
	logic                    ready;
	logic [mf2d_pkg::PIX_W-1:0] median_value;
	logic                    frame_last;
	modport source (output valid, median_value, frame_last, input ready);
	modport sink (input valid, median_value, frame_last, output ready);
endinterface

`default_nettype wire

[sv/mf2d_median.sv]
// pipelined 49-value median: compare matrix, rank count, one-hot select
// depends on mf2d_pkg
`default_nettype none

module mf2d_median (
	input  wire                clk,
	input  wire                arst_n,
	input  mf2d_pkg::med_ctl_t  in_ctl,
	input  mf2d_pkg::window_t   in_win,
	output logic               in_ready,
	output mf2d_pkg::med_ctl_t  out_ctl,
	output mf2d_pkg::pix_t      out_value,
	input  wire                out_ready
);

	logic valid_s3, last_s3, valid_s4, last_s4;
	mf2d_pkg::window_t vals_s3, vals_s4;
	logic [mf2d_pkg::WIN_N-1:0] beat_s3 [mf2d_pkg::WIN_N];
	logic [mf2d_pkg::WIN_N-1:0] beat_d [mf2d_pkg::WIN_N];
	logic [mf2d_pkg::RANK_W-1:0] rank_s4 [mf2d_pkg::WIN_N];
	logic out_valid_q, out_last_q;
	mf2d_pkg::pix_t out_value_q, sel_d;
	logic en_o, en_s4, en_s3;

	assign en_o  = !out_valid_q || out_ready;
	assign en_s4 = !valid_s4 || en_o;
	assign en_s3 = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	// ties broken by position so that every rank is unique
	always_comb begin
		for (int i = 0; i < mf2d_pkg::WIN_N; i++) begin
			for (int j = 0; j < mf2d_pkg::WIN_N; j++) begin
				beat_d[i][j] = (j < i) ? (in_win[j] <= in_win[i]) : (in_win[j] < in_win[i]);
			end
		end
	end

	always_comb begin
		sel_d = '0;
		for (int i = 0; i < mf2d_pkg::WIN_N; i++) begin
			if (rank_s4[i] == mf2d_pkg::RANK_W'(mf2d_pkg::MED_IDX)) begin
				sel_d = sel_d | vals_s4[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_ctl.valid;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_o) out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_ctl.valid) begin
			vals_s3 <= in_win;
			last_s3 <= in_ctl.last;
			beat_s3 <= beat_d;
		end
		if (en_s4 && valid_s3) begin
			vals_s4 <= vals_s3;
			last_s4 <= last_s3;
			for (int i = 0; i < mf2d_pkg::WIN_N; i++) begin
				rank_s4[i] <= mf2d_pkg::RANK_W'($countones(beat_s3[i]));
			end
		end
		if (en_o && valid_s4) begin
			out_value_q <= sel_d;
			out_last_q  <= last_s4;
		end
	end

	assign out_ctl.valid = out_valid_q;
	assign out_ctl.last  = out_last_q;
	assign out_value     = out_value_q;

endmodule

`default_nettype wire

[sv/median_filter_2d.sv]
// Two-dimensional median filter, zero padded, window side 2r+1 (r = 0..3), 8-bit pixels
// in raster order. One request is taken per clock unless stalled or in column catch-up:
// a pixel is written into a line memory of 1024 words x 8 byte lanes (lane = row modulo
// 8) and, once its column is complete, one window column is read back per request; a
// 7x7 window is built from the last 2r+1 columns and a pipelined rank network gives the
// median. An output appears when pixel j + r*W + r arrives; after the last pixel each
// flush request releases one output and the final output carries frame_last. In a frame
// with fewer than r*W + r pixels the block fetches up to r missing columns with ready
// low after the last pixel. A register write restarts the frame. No memory clearing pass.
// depends on mf2d_pkg, mf2d_if and mf2d_median
`default_nettype none

module median_filter_2d (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [1:0]                cfg_index,
	input  wire  [mf2d_pkg::DIM_W-1:0] cfg_data,
	mf2d_in_if.sink                   pixel_in,
	mf2d_out_if.source                result_out
);

	// configuration
	logic [mf2d_pkg::DIM_W-1:0] width_q, height_q, w_eff, h_eff;
	logic [mf2d_pkg::RAD_W-1:0] radius_q, r_eff;
	logic [mf2d_pkg::PEND_W-1:0] lag;
	logic cfg_hit;

	// frame position state
	logic [mf2d_pkg::ROW_W-1:0] in_row_q, in_row_nx, f_row_q, f_row_nx;
	logic [mf2d_pkg::COL_W-1:0] in_col_q, in_col_nx, f_col_q, f_col_nx;
	logic [mf2d_pkg::COL_W-1:0] out_row_q, out_row_nx, out_col_q, out_col_nx;
	logic [mf2d_pkg::PEND_W-1:0] pend_q, pend_nx;
	logic [mf2d_pkg::RAD_W-1:0] d_q, d_nx;
	logic in_done_q, in_done_nx;

	logic in_acc, pix_acc, flush_emit, pix_emit, emit_s0, last_s0;
	logic catchup, pix_fetch, fetch_s0;
	logic en_s1, en_s2, med_ready;

	// memory and stage 1
	logic [mf2d_pkg::WORD_W-1:0] mem [mf2d_pkg::MAX_WIDTH];
	logic [mf2d_pkg::WORD_W-1:0] rd_s1, word;
	logic fwd_hit_s1;
	logic [mf2d_pkg::BANK_W-1:0] fwd_lane_s1;
	mf2d_pkg::pix_t fwd_pix_s1;
	logic [mf2d_pkg::ROW_W-1:0] f_row_s1;
	logic [mf2d_pkg::COL_W-1:0] out_col_s1;
	logic fetch_s1, emit_s1, last_s1;

	logic signed [mf2d_pkg::ROW_W+1:0] rw [mf2d_pkg::MAX_WINDOW];
	logic signed [mf2d_pkg::COL_W+1:0] colx [mf2d_pkg::MAX_WINDOW];
	logic [mf2d_pkg::MAX_WINDOW-1:0] col_ok, act;
	logic [2:0] sel_m [mf2d_pkg::MAX_WINDOW];
	mf2d_pkg::column_t newcol;
	mf2d_pkg::column_t colq [mf2d_pkg::MAX_WINDOW-1];
	mf2d_pkg::column_t allcols [8];
	mf2d_pkg::window_t win_d, win_s2;
	logic valid_s2, last_s2;

	mf2d_pkg::med_ctl_t med_in, med_out;
	mf2d_pkg::pix_t med_value;

	// ---------------- configuration ----------------
	always_comb begin
		if (width_q == '0) w_eff = mf2d_pkg::DIM_W'(1);
		else if (width_q > mf2d_pkg::DIM_W'(mf2d_pkg::MAX_WIDTH))
			w_eff = mf2d_pkg::DIM_W'(mf2d_pkg::MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == '0) h_eff = mf2d_pkg::DIM_W'(1);
		else if (height_q > mf2d_pkg::DIM_W'(mf2d_pkg::MAX_HEIGHT))
			h_eff = mf2d_pkg::DIM_W'(mf2d_pkg::MAX_HEIGHT);
		else h_eff = height_q;
		r_eff = (radius_q > mf2d_pkg::RAD_W'(mf2d_pkg::RMAX)) ?
			mf2d_pkg::RAD_W'(mf2d_pkg::RMAX) : radius_q;
	end

	// r*W + r with a two-bit r
	assign lag = ({2'b00, w_eff} & {mf2d_pkg::PEND_W{r_eff[0]}}) +
		({1'b0, w_eff, 1'b0} & {mf2d_pkg::PEND_W{r_eff[1]}}) +
		{11'b0, r_eff};

	always_comb begin
		cfg_hit = 1'b0;
		if (cfg_we) begin
			unique case (mf2d_pkg::cfg_reg_t'(cfg_index)) inside
				mf2d_pkg::REG_WIDTH, mf2d_pkg::REG_HEIGHT,
				mf2d_pkg::REG_RADIUS: cfg_hit = 1'b1;
				default: cfg_hit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf2d_pkg::DIM_W'(256);
			height_q <= mf2d_pkg::DIM_W'(256);
			radius_q <= mf2d_pkg::RAD_W'(1);
		end else if (cfg_we) begin
			unique case (mf2d_pkg::cfg_reg_t'(cfg_index))
				mf2d_pkg::REG_WIDTH:  width_q  <= cfg_data;
				mf2d_pkg::REG_HEIGHT: height_q <= cfg_data;
				mf2d_pkg::REG_RADIUS: radius_q <= cfg_data[mf2d_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 0: request decode ----------------
	// columns still missing after the last pixel of a very short frame
	assign catchup = in_done_q && (d_q < r_eff);
	assign pixel_in.ready = en_s1 && !catchup;

	assign in_acc     = pixel_in.valid && pixel_in.ready;
	assign pix_acc    = in_acc && !pixel_in.command && !in_done_q;
	assign flush_emit = in_acc && pixel_in.command && in_done_q;
	assign pix_emit   = pix_acc && ((pend_q + mf2d_pkg::PEND_W'(1)) > lag);
	assign emit_s0    = pix_emit || flush_emit;
	assign last_s0    = emit_s0 && ({1'b0, out_row_q} == h_eff - mf2d_pkg::DIM_W'(1)) &&
		({1'b0, out_col_q} == w_eff - mf2d_pkg::DIM_W'(1));

	// a column is complete once r rows below it have arrived
	assign pix_fetch = pix_acc && (in_row_q >= mf2d_pkg::ROW_W'(r_eff));
	assign fetch_s0  = pix_fetch || flush_emit || (catchup && en_s1);

	always_comb begin
		in_row_nx  = in_row_q;
		in_col_nx  = in_col_q;
		in_done_nx = in_done_q;
		out_row_nx = out_row_q;
		out_col_nx = out_col_q;
		f_row_nx   = f_row_q;
		f_col_nx   = f_col_q;
		pend_nx    = pend_q + mf2d_pkg::PEND_W'(pix_acc) - mf2d_pkg::PEND_W'(emit_s0);
		d_nx       = d_q + mf2d_pkg::RAD_W'(fetch_s0) - mf2d_pkg::RAD_W'(emit_s0);
		if (pix_acc) begin
			if ({1'b0, in_col_q} + mf2d_pkg::DIM_W'(1) == w_eff) begin
				in_col_nx = '0;
				in_row_nx = in_row_q + mf2d_pkg::ROW_W'(1);
				if (in_row_q + mf2d_pkg::ROW_W'(1) == h_eff) in_done_nx = 1'b1;
			end else begin
				in_col_nx = in_col_q + mf2d_pkg::COL_W'(1);
			end
		end
		if (emit_s0) begin
			if ({1'b0, out_col_q} + mf2d_pkg::DIM_W'(1) == w_eff) begin
				out_col_nx = '0;
				out_row_nx = out_row_q + mf2d_pkg::COL_W'(1);
			end else begin
				out_col_nx = out_col_q + mf2d_pkg::COL_W'(1);
			end
		end
		if (fetch_s0) begin
			if ({1'b0, f_col_q} + mf2d_pkg::DIM_W'(1) == w_eff) begin
				f_col_nx = '0;
				f_row_nx = f_row_q + mf2d_pkg::ROW_W'(1);
			end else begin
				f_col_nx = f_col_q + mf2d_pkg::COL_W'(1);
			end
		end
		if (cfg_hit || last_s0) begin
			in_row_nx  = '0;
			in_col_nx  = '0;
			in_done_nx = 1'b0;
			out_row_nx = '0;
			out_col_nx = '0;
			f_row_nx   = '0;
			f_col_nx   = '0;
			pend_nx    = '0;
			d_nx       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_done_q <= 1'b0;
			out_row_q <= '0;
			out_col_q <= '0;
			f_row_q   <= '0;
			f_col_q   <= '0;
			pend_q    <= '0;
			d_q       <= '0;
		end else begin
			in_row_q  <= in_row_nx;
			in_col_q  <= in_col_nx;
			in_done_q <= in_done_nx;
			out_row_q <= out_row_nx;
			out_col_q <= out_col_nx;
			f_row_q   <= f_row_nx;
			f_col_q   <= f_col_nx;
			pend_q    <= pend_nx;
			d_q       <= d_nx;
		end
	end

	// ---------------- line memory ----------------
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			mem[in_col_q][{in_row_q[mf2d_pkg::BANK_W-1:0], 3'b000} +: mf2d_pkg::PIX_W] <=
				pixel_in.pixel;
		end
		if (fetch_s0) begin
			rd_s1 <= mem[f_col_q];
		end
	end

	// same-cycle write to the column being read is forwarded
	always_ff @(posedge clk) begin
		if (fetch_s0) begin
			fwd_hit_s1  <= pix_acc && (in_col_q == f_col_q);
			fwd_lane_s1 <= in_row_q[mf2d_pkg::BANK_W-1:0];
			fwd_pix_s1  <= pixel_in.pixel;
			f_row_s1    <= f_row_q;
			out_col_s1  <= out_col_q;
		end
	end

	// ---------------- stage 1: column assembly ----------------
	assign en_s1 = !emit_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else if (en_s1) begin
			fetch_s1 <= fetch_s0;
			emit_s1  <= emit_s0;
			last_s1  <= last_s0;
		end
	end

	always_comb begin
		word = rd_s1;
		if (fwd_hit_s1) word[{fwd_lane_s1, 3'b000} +: mf2d_pkg::PIX_W] = fwd_pix_s1;
		for (int k = 0; k < mf2d_pkg::MAX_WINDOW; k++) begin
			rw[k] = $signed({2'b00, f_row_s1}) + $signed((mf2d_pkg::ROW_W+2)'(k)) -
				$signed((mf2d_pkg::ROW_W+2)'(mf2d_pkg::RMAX));
			if (rw[k] >= 0 && rw[k] < $signed({2'b00, h_eff})) begin
				newcol[k] = word[{rw[k][mf2d_pkg::BANK_W-1:0], 3'b000} +: mf2d_pkg::PIX_W];
			end else begin
				newcol[k] = '0;
			end
		end
	end

	// shift line of the most recent fetched columns, newest first
	always_ff @(posedge clk) begin
		if (fetch_s1 && en_s1) begin
			colq[0] <= newcol;
			for (int i = 1; i < mf2d_pkg::MAX_WINDOW - 1; i++) colq[i] <= colq[i-1];
		end
	end

	always_comb begin
		allcols[0] = newcol;
		for (int i = 1; i < mf2d_pkg::MAX_WINDOW; i++) allcols[i] = colq[i-1];
		allcols[7] = '0;
		for (int c = 0; c < mf2d_pkg::MAX_WINDOW; c++) begin
			colx[c] = $signed({2'b00, out_col_s1}) + $signed((mf2d_pkg::COL_W+2)'(c)) -
				$signed((mf2d_pkg::COL_W+2)'(mf2d_pkg::RMAX));
			col_ok[c] = (colx[c] >= 0) && (colx[c] < $signed({1'b0, w_eff}));
			act[c] = (c >= mf2d_pkg::RMAX - int'(r_eff)) && (c <= mf2d_pkg::RMAX + int'(r_eff));
			sel_m[c] = 3'(mf2d_pkg::RMAX + int'(r_eff) - c);
		end
		// slots outside a smaller window pad half low and half high around the centre
		for (int k = 0; k < mf2d_pkg::MAX_WINDOW; k++) begin
			for (int c = 0; c < mf2d_pkg::MAX_WINDOW; c++) begin
				if (!(act[k] && act[c])) begin
					win_d[k*mf2d_pkg::MAX_WINDOW + c] =
						(k*mf2d_pkg::MAX_WINDOW + c < mf2d_pkg::MED_IDX) ? 8'h00 : 8'hff;
				end else if (col_ok[c]) begin
					win_d[k*mf2d_pkg::MAX_WINDOW + c] = allcols[sel_m[c]][k];
				end else begin
					win_d[k*mf2d_pkg::MAX_WINDOW + c] = 8'h00;
				end
			end
		end
	end

	// ---------------- stage 2: window register ----------------
	assign en_s2 = !valid_s2 || med_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && emit_s1) begin
			win_s2  <= win_d;
			last_s2 <= last_s1;
		end
	end

	assign med_in.valid = valid_s2;
	assign med_in.last  = last_s2;

	mf2d_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (med_in),
		.in_win    (win_s2),
		.in_ready  (med_ready),
		.out_ctl   (med_out),
		.out_value (med_value),
		.out_ready (result_out.ready)
	);

	assign result_out.valid        = med_out.valid;
	assign result_out.median_value = med_value;
	assign result_out.frame_last   = med_out.last;

`ifndef NO_ASSERTIONS
	a_fetch_lead: assert property (@(posedge clk) disable iff (!arst_n) d_q <= r_eff)
		else $error("fetch position ran ahead of the window");
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n) pend_q <= lag)
		else $error("pending output count above the lag");
	a_emit_fetch: assert property (@(posedge clk) disable iff (!arst_n) emit_s1 |-> fetch_s1)
		else $error("output issued without its window column");
	a_catchup_hold: assert property (@(posedge clk) disable iff (!arst_n)
		catchup |-> !pixel_in.ready)
		else $error("request taken during column catch-up");
`endif

endmodule

`default_nettype wire
